// ----- rtl/pbnf_pkg.sv -----
// Package for the page bitmap next-fit allocator.
// Holds the request/command types shared by the front end, queue and engine.
// No dependencies.
package pbnf_pkg;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // configuration register indexes
   localparam logic CSR_ARENA_READY = 1'b0;
   localparam logic CSR_ARENA_PAGES = 1'b1;

   localparam int REQ_BYTES_W = 27;
   localparam int FREE_OFF_W  = 24;
   localparam int COUNT_W     = 13;
   localparam int START_W     = 12;

   // decoded command passed from front end to engine
   typedef struct packed {
      logic                   is_free;
      logic                   usable;   // arena ready and request sane
      logic [REQ_BYTES_W-1:0] need;     // pages wanted (alloc) or page index (free)
   } cmd_type;

endpackage

// ----- rtl/pbnf_front.sv -----
// Front end: accepts requests, rounds sizes to pages and range-checks them.
// Depends on pbnf_pkg.
module pbnf_front #(
   parameter int PAGE_SHIFT = 12,
   parameter int EFF_W      = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic                              in_func,
   input  logic [pbnf_pkg::REQ_BYTES_W-1:0]  in_bytes,
   input  logic [pbnf_pkg::FREE_OFF_W-1:0]   in_offset,
   input  logic                              arena_ready,
   input  logic [EFF_W-1:0]                  eff_pages,
   output logic                              cmd_valid,
   input  logic                              cmd_ready,
   output pbnf_pkg::cmd_type                 cmd
);
   import pbnf_pkg::*;

   logic [REQ_BYTES_W:0] need_w;
   logic [REQ_BYTES_W:0] idx_w;
   logic                 full_ff, full_in;
   cmd_type              cmd_ff, cmd_in;

   assign need_w = ({1'b0, in_bytes} + ((REQ_BYTES_W+1)'(1) << PAGE_SHIFT)
                    - (REQ_BYTES_W+1)'(1)) >> PAGE_SHIFT;
   assign idx_w  = (REQ_BYTES_W+1)'(in_offset) >> PAGE_SHIFT;

   assign in_ready  = !full_ff || cmd_ready;
   assign cmd_valid = full_ff;
   assign cmd       = cmd_ff;

   // classify the incoming transaction
   always_comb begin
      full_in = full_ff;
      cmd_in  = cmd_ff;
      if (cmd_ready) full_in = 1'b0;
      if (in_valid && in_ready) begin
         full_in        = 1'b1;
         cmd_in.is_free = (in_func == FUNC_FREE);
         if (in_func == FUNC_FREE) begin
            cmd_in.need   = idx_w[REQ_BYTES_W-1:0];
            cmd_in.usable = arena_ready && (idx_w < (REQ_BYTES_W+1)'(eff_pages));
         end else begin
            cmd_in.need   = need_w[REQ_BYTES_W-1:0];
            cmd_in.usable = arena_ready && (need_w != '0)
                            && (need_w <= (REQ_BYTES_W+1)'(eff_pages));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else       full_ff <= full_in;
      cmd_ff <= cmd_in;
   end
endmodule

// ----- rtl/pbnf_fifo.sv -----
// Two-entry command queue between front end and engine.
// Depends on pbnf_pkg.
module pbnf_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  pbnf_pkg::cmd_type wr_data,
   output logic              rd_valid,
   input  logic              rd_ready,
   output pbnf_pkg::cmd_type rd_data
);
   import pbnf_pkg::*;

   cmd_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_valid && wr_ready) mem_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (wr_valid && wr_ready) wp_ff <= !wp_ff;
         if (rd_valid && rd_ready) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
      end
   end
endmodule

// ----- rtl/pbnf_engine.sv -----
// Back end: bitmap scan, run marking/clearing, counters and result register.
// Depends on pbnf_pkg; holds the page bitmap and run-length memory.
module pbnf_engine #(
   parameter int DEPTH = 4096,
   parameter int IDX_W = 12,
   parameter int EFF_W = 13
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  pbnf_pkg::cmd_type             cmd,
   input  logic [EFF_W-1:0]              eff_pages,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_granted,
   output logic [pbnf_pkg::START_W-1:0]  rsp_start,
   output logic [pbnf_pkg::COUNT_W-1:0]  rsp_freed,
   output logic [pbnf_pkg::COUNT_W-1:0]  rsp_live,
   output logic [pbnf_pkg::COUNT_W-1:0]  rsp_peak
);
   import pbnf_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_MARK  = 3'd3;
   localparam logic [2:0] S_RDLEN = 3'd4;
   localparam logic [2:0] S_UNMK  = 3'd5;
   localparam int CW = EFF_W + 1;

   logic             used_mem [DEPTH];
   logic [EFF_W-1:0] len_mem  [DEPTH];

   logic [2:0]       st_ff;
   logic [CW-1:0]    i_ff;     // window start
   logic [CW-1:0]    run_ff;   // free pages seen in window
   logic [CW-1:0]    hi_ff;    // scan limit
   logic             wrap_ff;
   logic [CW-1:0]    hint_ff;  // wrap limit
   logic [CW-1:0]    need_ff;
   logic [CW-1:0]    k_ff;
   logic [IDX_W-1:0] search_ff;
   logic [EFF_W-1:0] live_ff, peak_ff;
   logic             used_rd;
   logic [EFF_W-1:0] len_rd;
   logic             rd_pend_ff;
   logic             vld_ff;
   logic             g_ff;
   logic [START_W-1:0] s_ff;
   logic [COUNT_W-1:0] f_ff;
   logic [CW-1:0]    pos;
   logic [CW-1:0]    eff_w;
   logic [CW-1:0]    hint_c;

   assign eff_w  = CW'(eff_pages > EFF_W'(DEPTH) ? EFF_W'(DEPTH) : eff_pages);
   assign hint_c = (CW'(search_ff) < eff_w) ? CW'(search_ff) : '0;
   assign pos    = i_ff + run_ff;
   assign cmd_ready = (st_ff == S_IDLE) && !vld_ff;

   assign rsp_valid   = vld_ff;
   assign rsp_granted = g_ff;
   assign rsp_start   = s_ff;
   assign rsp_freed   = f_ff;
   assign rsp_live    = COUNT_W'(live_ff);
   assign rsp_peak    = COUNT_W'(peak_ff);

   // registered memory reads, address chosen by state
   always_ff @(posedge clock) begin
      used_rd <= used_mem[pos[IDX_W-1:0]];
      len_rd  <= len_mem[k_ff[IDX_W-1:0]];
   end

   // sequencer: clearing pass, scan one page per registered read, mark, free
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR; k_ff <= '0; vld_ff <= 1'b0; search_ff <= '0;
         live_ff <= '0; peak_ff <= '0; rd_pend_ff <= 1'b0;
      end else begin
         if (vld_ff && rsp_ready) vld_ff <= 1'b0;
         case (st_ff)
            S_CLEAR: begin
               used_mem[k_ff[IDX_W-1:0]] <= 1'b0;
               len_mem[k_ff[IDX_W-1:0]]  <= '0;
               k_ff <= k_ff + 1'b1;
               if (k_ff == CW'(DEPTH - 1)) st_ff <= S_IDLE;
            end
            S_IDLE: if (cmd_valid && cmd_ready) begin
               g_ff <= 1'b0; s_ff <= '0; f_ff <= '0;
               need_ff <= CW'(cmd.need);
               k_ff <= CW'(cmd.need);
               if (!cmd.usable) begin
                  vld_ff <= 1'b1;
               end else if (cmd.is_free) begin
                  st_ff <= S_RDLEN; rd_pend_ff <= 1'b1;
               end else begin
                  i_ff <= hint_c; run_ff <= '0; hi_ff <= eff_w;
                  hint_ff <= hint_c; wrap_ff <= 1'b0;
                  rd_pend_ff <= 1'b1; st_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (i_ff + need_ff > hi_ff) begin
                  if (!wrap_ff) begin
                     wrap_ff <= 1'b1; i_ff <= '0; run_ff <= '0;
                     hi_ff <= hint_ff; rd_pend_ff <= 1'b1;
                  end else begin
                     vld_ff <= 1'b1; st_ff <= S_IDLE;
                  end
               end else if (run_ff == need_ff) begin
                  s_ff <= START_W'(i_ff); g_ff <= 1'b1; k_ff <= '0;
                  len_mem[i_ff[IDX_W-1:0]] <= EFF_W'(need_ff);
                  st_ff <= S_MARK;
               end else if (rd_pend_ff) begin
                  rd_pend_ff <= 1'b0;
               end else if (used_rd) begin
                  i_ff <= pos + 1'b1; run_ff <= '0; rd_pend_ff <= 1'b1;
               end else begin
                  run_ff <= run_ff + 1'b1; rd_pend_ff <= 1'b1;
               end
            end
            S_MARK: begin
               used_mem[IDX_W'(i_ff + k_ff)] <= 1'b1;
               k_ff <= k_ff + 1'b1;
               if (k_ff + 1'b1 == need_ff) begin
                  search_ff <= (i_ff + need_ff >= eff_w) ? '0 : IDX_W'(i_ff + need_ff);
                  live_ff <= live_ff + EFF_W'(need_ff);
                  if (live_ff + EFF_W'(need_ff) > peak_ff) peak_ff <= live_ff + EFF_W'(need_ff);
                  vld_ff <= 1'b1; st_ff <= S_IDLE;
               end
            end
            S_RDLEN: begin
               if (rd_pend_ff) rd_pend_ff <= 1'b0;
               else if (len_rd == '0) begin
                  vld_ff <= 1'b1; st_ff <= S_IDLE;
               end else begin
                  i_ff <= k_ff; need_ff <= CW'(len_rd); k_ff <= '0;
                  f_ff <= COUNT_W'(len_rd);
                  len_mem[k_ff[IDX_W-1:0]] <= '0;
                  live_ff <= (live_ff >= len_rd) ? live_ff - len_rd : '0;
                  if (k_ff < CW'(search_ff)) search_ff <= IDX_W'(k_ff);
                  st_ff <= S_UNMK;
               end
            end
            S_UNMK: begin
               if (i_ff + k_ff < CW'(DEPTH)) used_mem[IDX_W'(i_ff + k_ff)] <= 1'b0;
               k_ff <= k_ff + 1'b1;
               if (k_ff + 1'b1 >= need_ff) begin
                  vld_ff <= 1'b1; st_ff <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- rtl/page_bitmap_next_fit_allocator_top.sv -----
// Next-fit page allocator: an allocate scans the bitmap one page at a time and then
// marks the run it found; a free reads the stored run length and clears that run,
// and a rejected request is answered without a scan. One request is in the engine at
// a time; three more wait in the front end and queue. After reset a clearing pass
// over all ARENA_PAGES entries runs before any request is taken; configuration
// writes are accepted throughout. Reset is synchronous.
module page_bitmap_next_fit_allocator_top #(
   parameter int ARENA_PAGES = 4096,
   parameter int PAGE_BYTES  = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // req_bytes[26:0], free_offset[50:27]
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // granted, start_page, freed, live, peak
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [12:0] csr_wdata
);
   import pbnf_pkg::*;

   localparam int IDX_W = $clog2(ARENA_PAGES);
   localparam int EFF_W = 13;

   logic        ready_ff;
   logic [12:0] pages_ff;
   cmd_type     f_cmd, q_cmd;
   logic        f_v, f_r, q_v, q_r;
   logic        g;
   logic [START_W-1:0] s;
   logic [COUNT_W-1:0] fr, lv, pk;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0; pages_ff <= 13'(ARENA_PAGES > 8191 ? 8191 : ARENA_PAGES);
      end else if (csr_we) begin
         if (csr_index == CSR_ARENA_READY) ready_ff <= csr_wdata[0];
         else                              pages_ff <= csr_wdata;
      end
   end

   pbnf_front #(.PAGE_SHIFT($clog2(PAGE_BYTES)), .EFF_W(EFF_W)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_func(req_tuser), .in_bytes(req_tdata[26:0]), .in_offset(req_tdata[50:27]),
      .arena_ready(ready_ff), .eff_pages(pages_ff),
      .cmd_valid(f_v), .cmd_ready(f_r), .cmd(f_cmd));

   pbnf_fifo u_fifo (
      .clock, .reset, .wr_valid(f_v), .wr_ready(f_r), .wr_data(f_cmd),
      .rd_valid(q_v), .rd_ready(q_r), .rd_data(q_cmd));

   pbnf_engine #(.DEPTH(ARENA_PAGES), .IDX_W(IDX_W), .EFF_W(EFF_W)) u_engine (
      .clock, .reset, .cmd_valid(q_v), .cmd_ready(q_r), .cmd(q_cmd),
      .eff_pages(pages_ff), .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_granted(g), .rsp_start(s), .rsp_freed(fr), .rsp_live(lv), .rsp_peak(pk));

   assign rsp_tdata = {4'b0, pk, lv, fr, s, g};
endmodule
